// File: hdl/snsub_pkg.sv
// Shared types and constants for the spectral noise subtractor.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package snsub_pkg;

  localparam int BINS        = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int IDX_W       = $clog2(BINS);
  localparam int K_W         = 10;
  localparam int E_W         = 2 * SAMPLE_BITS;   // energy of one bin
  localparam int T_W         = E_W + K_W - 8;     // weighted noise threshold
  localparam int REM_W       = E_W + 1;
  localparam int Q_W         = 32;                // gain ratio, 32 fraction bits
  localparam int G_W         = 16;                // gain, 16 fraction bits
  localparam int DIV_STEPS   = Q_W;
  localparam int SQRT_STEPS  = Q_W / 2;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_LEARN  = 2'd1,
    MODE_REDUCE = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_UPD,
    ST_THR,
    ST_DEC,
    ST_DIV,
    ST_SINIT,
    ST_SQRT,
    ST_GAIN,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic sq1;
    logic sq2;
    logic upd;
    logic thr;
    logic dec;
    logic div_step;
    logic sinit;
    logic sqrt_step;
    logic gain;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic t_zero;
    logic t_ge_e;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/snsub_ctrl.sv
// Sequencer for the spectral noise subtractor: steps one item through the datapath.
// Depends on snsub_pkg.
`default_nettype none
module snsub_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire snsub_pkg::status_t status,
  output snsub_pkg::cmd_t        cmd
);
  import snsub_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic              slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SQ1;
      ST_SQ1:   state_next = ST_SQ2;
      ST_SQ2:   state_next = ST_UPD;
      ST_UPD:   state_next = ST_THR;
      ST_THR:   state_next = ST_DEC;
      ST_DEC: begin
        if (status.t_zero || status.t_ge_e) state_next = ST_GAIN;
        else state_next = ST_DIV;
      end
      ST_DIV:   if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_SINIT;
      ST_SINIT: state_next = ST_SQRT;
      ST_SQRT:  if (cnt == CNT_W'(SQRT_STEPS - 1)) state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_PUSH;
      ST_PUSH:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_SQ1:   cmd.sq1 = 1'b1;
      ST_SQ2:   cmd.sq2 = 1'b1;
      ST_UPD:   cmd.upd = 1'b1;
      ST_THR:   cmd.thr = 1'b1;
      ST_DEC:   cmd.dec = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_SINIT: cmd.sinit = 1'b1;
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_GAIN:  cmd.gain = 1'b1;
      ST_PUSH:  cmd.push = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV || state == ST_SQRT) cnt <= cnt + 1'b1;
      else cnt <= '0;
      if (cmd.push) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_SQ1)
    else $error("accepted item did not start the sequence");
  a_div_len : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == CNT_W'(DIV_STEPS - 1)) |=> state == ST_SINIT)
    else $error("divide did not end after its last step");
  a_push_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_PUSH)
    else $error("result shown without a push");
`endif

endmodule
`default_nettype wire

// File: hdl/snsub_dp.sv
// Datapath: energy, noise profile memory, threshold, divide, square root, gain.
// Depends on snsub_pkg; driven by snsub_ctrl.
`default_nettype none
module snsub_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire snsub_pkg::cmd_t               cmd,
  output snsub_pkg::status_t                 status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [snsub_pkg::K_W-1:0]     cfg_wr_data,
  input  wire logic signed [snsub_pkg::SAMPLE_BITS-1:0] bin_real,
  input  wire logic signed [snsub_pkg::SAMPLE_BITS-1:0] bin_imag,
  input  wire logic                          learn_start,
  input  wire logic                          learn_stop,
  output logic signed [snsub_pkg::SAMPLE_BITS-1:0] out_real,
  output logic signed [snsub_pkg::SAMPLE_BITS-1:0] out_imag,
  output logic                               end_of_frame
);
  import snsub_pkg::*;

  logic [E_W-1:0]         profile [BINS];
  logic [E_W-1:0]         rd_q;

  logic [K_W-1:0]         k;
  logic [IDX_W-1:0]       bin_index;
  mode_t                  mode;
  logic                   learning;

  logic [SAMPLE_BITS-1:0] raw_re, raw_im, mr, mi, res_re, res_im;
  logic                   nr, ni, pass, zero;
  logic [E_W-1:0]         e, nz, nz_new;
  logic [T_W-1:0]         t;
  logic [REM_W-1:0]       rem, rem2;
  logic [Q_W-1:0]         quot, sq_rem, root;
  logic [Q_W-2:0]         sbit;
  logic [Q_W:0]           ssum;
  logic [E_W+K_W-1:0]     prod_t;
  logic [SAMPLE_BITS+G_W-1:0] gr, gi;

  assign nr = raw_re[SAMPLE_BITS-1];
  assign ni = raw_im[SAMPLE_BITS-1];
  assign mr = nr ? (~raw_re + 1'b1) : raw_re;
  assign mi = ni ? (~raw_im + 1'b1) : raw_im;

  assign status.t_zero = (t == '0);
  assign status.t_ge_e = (t >= T_W'(e));

  always_comb begin
    if (mode == MODE_CLEAR) nz_new = '0;
    else if (mode == MODE_LEARN && e > rd_q) nz_new = e;
    else nz_new = rd_q;
  end

  assign prod_t = nz * k;
  assign rem2   = rem << 1;
  assign ssum   = {1'b0, sq_rem} - ({1'b0, root} + {2'b0, sbit});
  assign gr     = mr * root[G_W-1:0];
  assign gi     = mi * root[G_W-1:0];

  // profile memory: read at accept, written back during the update step
  always_ff @(posedge clk) begin
    if (cmd.accept) rd_q <= profile[bin_index];
    if (cmd.upd && mode != MODE_REDUCE) profile[bin_index] <= nz_new;
  end

  // control state: register, bin counter within the frame, and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      bin_index <= '0;
      mode <= MODE_CLEAR;
      learning <= 1'b0;
    end else begin
      if (cfg_wr_en) k <= cfg_wr_data;
      if (cmd.accept && bin_index == '0) begin
        // stop wins over start
        if (learn_stop) begin
          learning <= 1'b0;
          mode <= MODE_REDUCE;
        end else if (learn_start && !learning) begin
          learning <= 1'b1;
          mode <= MODE_CLEAR;
        end
      end
      if (cmd.push) begin
        if (bin_index == IDX_W'(BINS - 1)) begin
          bin_index <= '0;
          if (mode == MODE_CLEAR) mode <= MODE_LEARN;
        end else begin
          bin_index <= bin_index + 1'b1;
        end
      end
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      raw_re <= bin_real;
      raw_im <= bin_imag;
    end
    if (cmd.sq1) e <= E_W'(mr) * E_W'(mr);
    if (cmd.sq2) e <= e + E_W'(mi) * E_W'(mi);
    if (cmd.upd) nz <= nz_new;
    if (cmd.thr) t <= prod_t[E_W+K_W-1:8];
    if (cmd.dec) begin
      pass <= status.t_zero;
      zero <= status.t_ge_e;
      rem  <= REM_W'(e) - REM_W'(t);
      quot <= '0;
    end
    if (cmd.div_step) begin
      if (rem2 >= REM_W'(e)) begin
        rem  <= rem2 - REM_W'(e);
        quot <= {quot[Q_W-2:0], 1'b1};
      end else begin
        rem  <= rem2;
        quot <= {quot[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.sinit) begin
      sq_rem <= quot;
      root   <= '0;
      sbit   <= (Q_W-1)'(1) << (Q_W - 2);
    end
    if (cmd.sqrt_step) begin
      if (!ssum[Q_W]) begin
        sq_rem <= ssum[Q_W-1:0];
        root   <= (root >> 1) + Q_W'(sbit);
      end else begin
        root   <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.gain) begin
      if (pass) begin
        res_re <= raw_re;
        res_im <= raw_im;
      end else if (zero) begin
        res_re <= '0;
        res_im <= '0;
      end else begin
        res_re <= nr ? (~gr[SAMPLE_BITS+G_W-1:G_W] + 1'b1) : gr[SAMPLE_BITS+G_W-1:G_W];
        res_im <= ni ? (~gi[SAMPLE_BITS+G_W-1:G_W] + 1'b1) : gi[SAMPLE_BITS+G_W-1:G_W];
      end
    end
    if (cmd.push) begin
      out_real     <= res_re;
      out_imag     <= res_im;
      end_of_frame <= (bin_index == IDX_W'(BINS - 1));
    end
  end

endmodule
`default_nettype wire

// File: hdl/spectral_noise_subtractor_unit.sv
// Top level of the spectral noise subtractor: controller plus datapath.
// Depends on snsub_pkg, snsub_ctrl and snsub_dp.
// One FFT bin per item, BINS bins to a frame. When a gain must be computed, an item
// runs a 32-step restoring divide and then a 16-step square root, one step per cycle;
// a bin that passes unchanged or is zeroed skips both. One item is in work at a time;
// a finished result waits in the output register while the next item is taken. The
// noise profile is a 1024 x 48 memory with no reset; start a clear/learn frame
// before switching to reduce.
`default_nettype none
module spectral_noise_subtractor_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [snsub_pkg::K_W-1:0]            cfg_wr_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [snsub_pkg::SAMPLE_BITS-1:0] bin_real,
  input  wire logic signed [snsub_pkg::SAMPLE_BITS-1:0] bin_imag,
  input  wire logic                                 learn_start,
  input  wire logic                                 learn_stop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [snsub_pkg::SAMPLE_BITS-1:0]  out_real,
  output logic signed [snsub_pkg::SAMPLE_BITS-1:0]  out_imag,
  output logic                                      end_of_frame
);
  import snsub_pkg::*;

  cmd_t    cmd;
  status_t status;

  snsub_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  snsub_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .bin_real     (bin_real),
    .bin_imag     (bin_imag),
    .learn_start  (learn_start),
    .learn_stop   (learn_stop),
    .out_real     (out_real),
    .out_imag     (out_imag),
    .end_of_frame (end_of_frame)
  );

endmodule
`default_nettype wire

// File: dv/spectral_noise_subtractor_unit_tb.sv
// Self-checking testbench for spectral_noise_subtractor_unit: table-driven
// directed bins, then random bins through a clear frame and a learn frame.
// Depends on snsub_pkg and the RTL of the unit.
`default_nettype none
module spectral_noise_subtractor_unit_tb;
  import snsub_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam int N_DIRECTED = 10;
  localparam int N_RANDOM = 1250 - N_DIRECTED;

  typedef struct {
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
    logic eof;
  } bin_out_t;

  typedef struct {
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
    logic start;
    logic stop;
  } bin_in_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [K_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] bin_real = '0;
  logic signed [SB-1:0] bin_imag = '0;
  logic learn_start = 1'b0;
  logic learn_stop = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_real;
  logic signed [SB-1:0] out_imag;
  logic end_of_frame;

  spectral_noise_subtractor_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .bin_real(bin_real), .bin_imag(bin_imag),
    .learn_start(learn_start), .learn_stop(learn_stop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_real(out_real), .out_imag(out_imag), .end_of_frame(end_of_frame)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [K_W-1:0] weight_k;
  logic [IDX_W-1:0] cur_bin;
  mode_t cur_mode;
  logic learning;
  logic [E_W-1:0] noise_mem [BINS];

  bin_out_t pending_bins[$];
  int bins_sent = 0;
  bit failed = 1'b0;

  function automatic logic [63:0] magnitude(logic signed [SB-1:0] v);
    longint s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic signed [SB-1:0] scale(logic signed [SB-1:0] v,
                                                 logic [63:0] g);
    logic [63:0] m;
    m = (magnitude(v) * g) >> 16;
    return (v < 0) ? -m[SB-1:0] : m[SB-1:0];
  endfunction

  function automatic bin_out_t subtract_noise(bin_in_t b);
    bin_out_t r;
    logic [63:0] e, nz, t, root, bitv, q;
    logic [95:0] num;
    e = magnitude(b.re) * magnitude(b.re) + magnitude(b.im) * magnitude(b.im);
    if (cur_bin == 0) begin
      if (b.start && !learning) begin
        learning = 1'b1;
        cur_mode = MODE_CLEAR;
      end
      if (b.stop) begin
        learning = 1'b0;
        cur_mode = MODE_REDUCE;
      end
    end
    if (cur_mode == MODE_CLEAR) noise_mem[cur_bin] = '0;
    else if (cur_mode == MODE_LEARN && e > noise_mem[cur_bin]) noise_mem[cur_bin] = e;
    nz = noise_mem[cur_bin];
    t = (nz * weight_k) >> 8;  // cannot saturate at these widths
    if (t == 0) begin
      r.re = b.re;
      r.im = b.im;
    end else if (t >= e) begin
      r.re = '0;
      r.im = '0;
    end else begin
      num = {32'd0, e - t} << 32;
      q = num / e;
      root = 0;
      bitv = 64'd1 << 30;
      while (bitv != 0) begin
        if (q >= root + bitv) begin
          q = q - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      r.re = scale(b.re, root);
      r.im = scale(b.im, root);
    end
    r.eof = (cur_bin == BINS - 1);
    if (cur_bin == BINS - 1 && cur_mode == MODE_CLEAR) cur_mode = MODE_LEARN;
    cur_bin = cur_bin + 1'b1;
    return r;
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    logic signed [SB-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = S_MAX;
      2: v = S_MIN;
      default: begin
        v = SB'($urandom);
        v = v >>> $urandom_range(0, SB - 1);
      end
    endcase
    return v;
  endfunction

  // send one item; a typed expectation overrides the predicted one
  task automatic send_bin(bin_in_t b, bit typed, bin_out_t want);
    bin_out_t r;
    bit quiet;
    quiet = (bins_sent >= 700 && bins_sent < 1000);
    while (!quiet && $urandom_range(0, 99) < 14) @(negedge clk);
    bin_real = b.re;
    bin_imag = b.im;
    learn_start = b.start;
    learn_stop = b.stop;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = subtract_noise(b);
    pending_bins.push_back(typed ? want : r);
    bins_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_weight(logic [K_W-1:0] k);
    while (pending_bins.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_wr_data = k;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    weight_k = k;
  endtask

  // receiver: random stalls, one long hold-off, one calm stretch
  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (bins_sent >= 300 && held < 400) begin
        out_stall = 1'b1;
        held++;
      end else if (bins_sent >= 700 && bins_sent < 1000) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 14);
      end
    end
  end

  always @(posedge clk) begin
    bin_out_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        $error("unexpected result: out_real=%0d out_imag=%0d", out_real, out_imag);
        failed = 1'b1;
      end else begin
        w = pending_bins.pop_front();
        if (out_real !== w.re) begin
          $error("out_real: expected %0d, got %0d", w.re, out_real);
          failed = 1'b1;
        end
        if (out_imag !== w.im) begin
          $error("out_imag: expected %0d, got %0d", w.im, out_imag);
          failed = 1'b1;
        end
        if (end_of_frame !== w.eof) begin
          $error("end_of_frame: expected %0d, got %0d", w.eof, end_of_frame);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #(8 * 3_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // frame-start pulses: {start, stop} per frame number
  logic [1:0] frame_pulses [5] = '{2'b10, 2'b10, 2'b11, 2'b10, 2'b01};
  logic [K_W-1:0] weight_plan [8] = '{0, 512, 1023, 256, 1, 100, 700, 512};

  bin_in_t directed [N_DIRECTED];

  initial begin
    bin_in_t b;
    bin_out_t want;
    int n;
    weight_k = '0;
    cur_bin = '0;
    cur_mode = MODE_CLEAR;
    learning = 1'b0;
    // first frame is in clear mode: profile is zero, so bins pass unchanged
    directed[0] = '{S_MAX, S_MAX, 1'b1, 1'b0};
    directed[1] = '{S_MIN, S_MIN, 1'b0, 1'b0};
    directed[2] = '{'0, '0, 1'b0, 1'b0};
    directed[3] = '{S_MIN, S_MAX, 1'b0, 1'b1};
    directed[4] = '{-1, 1, 1'b1, 1'b0};
    directed[5] = '{1, -1, 1'b1, 1'b1};
    directed[6] = '{S_MAX, '0, 1'b0, 1'b0};
    directed[7] = '{'0, S_MIN, 1'b0, 1'b0};
    directed[8] = '{24'h555555, 24'hAAAAAA, 1'b0, 1'b0};
    directed[9] = '{24'hAAAAAA, 24'h555555, 1'b0, 1'b0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_weight(10'd300);
    for (int i = 0; i < N_DIRECTED; i++) begin
      want = '{directed[i].re, directed[i].im, 1'b0};
      send_bin(directed[i], 1'b1, want);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      n = bins_sent;
      if (n % 256 == 0) write_weight(((n / 256) % 8 == 6) ?
                                     K_W'($urandom_range(0, 1023)) :
                                     weight_plan[(n / 256) % 8]);
      b.re = rand_sample();
      b.im = rand_sample();
      if (n % BINS == 0) begin
        b.start = frame_pulses[n / BINS][1];
        b.stop = frame_pulses[n / BINS][0];
      end else begin
        b.start = 1'($urandom_range(0, 1));
        b.stop = 1'($urandom_range(0, 1));
      end
      send_bin(b, 1'b0, want);
    end
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/snsub_pkg.sv
hdl/snsub_ctrl.sv
hdl/snsub_dp.sv
hdl/spectral_noise_subtractor_unit.sv
dv/spectral_noise_subtractor_unit_tb.sv
